### design/pmbh_pkg.sv
`default_nettype none

package pmbh_pkg;

    // Meter floor of -60 dB in Q7.8, and the span that maps onto the display.
    localparam logic signed [15:0] LVL_FLOOR = -16'sd15360;
    localparam logic signed [17:0] LVL_SPAN  = 18'sd15360;

    // Height = floor(4 * (db + 15360) / 15). The division by 15 is a multiply
    // by ceil(2^20 / 15) and a shift, exact for every in-range operand.
    localparam logic signed [17:0] NORM_RECIP = 18'sd69906;
    localparam logic [12:0]        NORM_FULL  = 13'd4096;
    localparam logic [12:0]        VIS_MIN    = 13'd8;
    localparam logic [13:0]        HOLD_GAP   = 14'd82;

    // Operand selection for the shared multiplier.
    localparam logic [1:0] MUL_LEVEL  = 2'd0;
    localparam logic [1:0] MUL_HOLD   = 2'd1;
    localparam logic [1:0] MUL_NORM_L = 2'd2;
    localparam logic [1:0] MUL_NORM_H = 2'd3;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       upd_level;
        logic       hold_eval;
        logic       upd_hold;
        logic       load_lnorm;
        logic       load_out;
    } pmbh_cmd_t;

endpackage

`default_nettype wire

### design/pmbh_ctrl.sv
`default_nettype none

module pmbh_ctrl
    import pmbh_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output pmbh_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD1 = 3'd1;
    localparam logic [2:0] ST_HOLD = 3'd2;
    localparam logic [2:0] ST_NL   = 3'd3;
    localparam logic [2:0] ST_NH   = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_LEVEL;
                    state_next  = ST_ADD1;
                end
            end
            ST_ADD1: begin
                cmd.upd_level = 1'b1;
                state_next    = ST_HOLD;
            end
            ST_HOLD: begin
                cmd.hold_eval = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_HOLD;
                state_next    = ST_NL;
            end
            ST_NL: begin
                cmd.upd_hold = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_NORM_L;
                state_next   = ST_NH;
            end
            ST_NH: begin
                cmd.load_lnorm = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_NORM_H;
                state_next     = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/pmbh_dp.sv
`default_nettype none

module pmbh_dp
    import pmbh_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pmbh_cmd_t          cmd,
    input  wire logic [15:0]        attack_coeff,
    input  wire logic [15:0]        release_coeff,
    input  wire logic [9:0]         hold_ticks,
    input  wire logic signed [15:0] raw_level_db,
    output logic signed [15:0]      level_db,
    output logic signed [15:0]      hold_db,
    output logic [12:0]             level_norm,
    output logic [12:0]             hold_norm,
    output logic                    bar_visible,
    output logic                    hold_line_visible
);

    logic signed [15:0] level_reg, level_next;
    logic signed [15:0] held_reg, held_next;
    logic [9:0]         count_reg, count_next;
    logic               decay_reg, decay_next;
    logic signed [35:0] prod_reg;
    logic [12:0]        lnorm_reg;

    logic signed [15:0] out_level_reg, out_held_reg;
    logic [12:0]        out_lnorm_reg, out_hnorm_reg;
    logic               out_bar_reg, out_line_reg;

    logic signed [17:0] mul_a, mul_b;
    logic signed [16:0] lvl_diff, hold_diff;
    logic signed [17:0] step;
    logic [9:0]         count_dec;
    logic [12:0]        hnorm;

    // Operand for the height multiply: 4 * (db + 60 dB). Out-of-range values
    // wrap here and are replaced by the clip afterward.
    function automatic logic signed [17:0] norm_operand(input logic signed [15:0] db);
        logic signed [17:0] x;
        x = 18'(db) + LVL_SPAN;
        return x <<< 2;
    endfunction

    function automatic logic [12:0] clip_norm(input logic signed [15:0] db,
                                              input logic signed [35:0] p);
        logic [12:0] r;
        if (db <= LVL_FLOOR) begin
            r = '0;
        end else if (db >= 16'sd0) begin
            r = NORM_FULL;
        end else begin
            r = p[32:20];
        end
        return r;
    endfunction

    assign lvl_diff  = 17'(raw_level_db) - 17'(level_reg);
    assign hold_diff = 17'(level_reg) - 17'(held_reg);
    // Arithmetic shift of the product: floor(coeff * diff / 65536).
    assign step      = prod_reg[33:16];
    assign count_dec = (count_reg == '0) ? '0 : count_reg - 10'd1;
    assign hnorm     = clip_norm(held_reg, prod_reg);

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_LEVEL: begin
                mul_a = (raw_level_db > level_reg) ? {2'b00, attack_coeff}
                                                   : {2'b00, release_coeff};
                mul_b = 18'(lvl_diff);
            end
            MUL_HOLD: begin
                mul_a = {2'b00, release_coeff};
                mul_b = 18'(hold_diff);
            end
            MUL_NORM_L: begin
                mul_a = norm_operand(level_reg);
                mul_b = NORM_RECIP;
            end
            MUL_NORM_H: begin
                mul_a = norm_operand(held_reg);
                mul_b = NORM_RECIP;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        level_next = level_reg;
        held_next  = held_reg;
        count_next = count_reg;
        decay_next = decay_reg;
        if (cmd.upd_level) begin
            level_next = 16'(18'(level_reg) + step);
        end
        if (cmd.hold_eval) begin
            if (level_reg >= held_reg) begin
                held_next  = level_reg;
                count_next = hold_ticks;
                decay_next = 1'b0;
            end else begin
                count_next = count_dec;
                decay_next = (count_dec == '0);
            end
        end
        if (cmd.upd_hold && decay_reg) begin
            held_next = 16'(18'(held_reg) + step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LVL_FLOOR;
            held_reg  <= LVL_FLOOR;
            count_reg <= '0;
            decay_reg <= 1'b0;
        end else begin
            level_reg <= level_next;
            held_reg  <= held_next;
            count_reg <= count_next;
            decay_reg <= decay_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.load_lnorm) begin
            lnorm_reg <= clip_norm(level_reg, prod_reg);
        end
        if (cmd.load_out) begin
            out_level_reg <= level_reg;
            out_held_reg  <= held_reg;
            out_lnorm_reg <= lnorm_reg;
            out_hnorm_reg <= hnorm;
            out_bar_reg   <= (lnorm_reg > VIS_MIN);
            out_line_reg  <= (hnorm > VIS_MIN) &&
                             ({1'b0, hnorm} > ({1'b0, lnorm_reg} + HOLD_GAP));
        end
    end

    assign level_db          = out_level_reg;
    assign hold_db           = out_held_reg;
    assign level_norm        = out_lnorm_reg;
    assign hold_norm         = out_hnorm_reg;
    assign bar_visible       = out_bar_reg;
    assign hold_line_visible = out_line_reg;

endmodule

`default_nettype wire

### design/peak_meter_ballistics_hold_core.sv
`default_nettype none

// Peak meter ballistics with peak hold. Each input transaction carries one
// refresh tick's raw peak level in dB (signed Q7.8) and produces exactly one
// output transaction: the smoothed level, the peak-hold level, both mapped
// onto a 0..4096 display height over -60..0 dB, and the bar and hold-line
// visibility flags. The block cannot take the next tick until it is through
// with the current one: all products (the attack/release step, the hold
// decay step and the two height scalings) go through a single shared
// 18 x 18 multiplier, one product per cycle, and the hold decision waits for
// the new smoothed level. A finished result sits in an output register, so
// the next tick is taken while that result waits for m_ready; the block only
// stalls in its final cycle when the previous result has not yet been taken.
// Coefficients, hold time and state reset to attack 0.5, release 2048/65536,
// 60 ticks of hold and both levels at -60 dB. Registers are to be written
// through the APB port only while no tick is in flight; it is not enforced.
module peak_meter_ballistics_hold_core
    import pmbh_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_raw_level_db,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_level_db,
    output logic signed [15:0]      m_hold_db,
    output logic [12:0]             m_level_norm,
    output logic [12:0]             m_hold_norm,
    output logic                    m_bar_visible,
    output logic                    m_hold_line_visible
);

    // Register map: attack coefficient at 0x0, release coefficient at 0x4,
    // hold time in ticks at 0x8. Writes to 0xC..0xF are dropped.
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_RELEASE = 2'd1;
    localparam logic [1:0] REG_HOLD    = 2'd2;

    logic [15:0] attack_reg;
    logic [15:0] release_reg;
    logic [9:0]  hold_ticks_reg;
    logic        wr_en;
    pmbh_cmd_t   cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg     <= 16'd32768;
            release_reg    <= 16'd2048;
            hold_ticks_reg <= 10'd60;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_ATTACK:  attack_reg     <= pwdata[15:0];
                REG_RELEASE: release_reg    <= pwdata[15:0];
                REG_HOLD:    hold_ticks_reg <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ATTACK:  prdata = {16'd0, attack_reg};
            REG_RELEASE: prdata = {16'd0, release_reg};
            REG_HOLD:    prdata = {22'd0, hold_ticks_reg};
            default:     prdata = '0;
        endcase
    end

    // The controller sequences the shared multiplier and owns both
    // handshakes; the datapath holds the meter state and the result register.
    pmbh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pmbh_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .attack_coeff      (attack_reg),
        .release_coeff     (release_reg),
        .hold_ticks        (hold_ticks_reg),
        .raw_level_db      (s_raw_level_db),
        .level_db          (m_level_db),
        .hold_db           (m_hold_db),
        .level_norm        (m_level_norm),
        .hold_norm         (m_hold_norm),
        .bar_visible       (m_bar_visible),
        .hold_line_visible (m_hold_line_visible)
    );

endmodule

`default_nettype wire

### sim/tb_peak_meter_ballistics_hold_core.sv
`timescale 1ns / 100ps

module tb_peak_meter_ballistics_hold_core;
    import pmbh_pkg::*;

    // Register map, one 32-bit word per register.
    localparam int REG_ATTACK  = 0;
    localparam int REG_RELEASE = 1;
    localparam int REG_HOLD    = 2;

    // Meter constants, in Q7.8 dB and display height units.
    localparam int FLOOR_DB    = -15360;
    localparam int FULL_HEIGHT = 4096;
    localparam int SHOW_MIN    = 8;
    localparam int HOLD_MARGIN = 82;

    localparam int LONG_STALL   = 300;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_TICKS = 480;

    typedef struct {
        int level_db;
        int hold_db;
        int level_norm;
        int hold_norm;
        int bar_visible;
        int hold_line_visible;
    } meter_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_raw_level_db = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_level_db;
    logic signed [15:0] m_hold_db;
    logic [12:0]        m_level_norm;
    logic [12:0]        m_hold_norm;
    logic               m_bar_visible;
    logic               m_hold_line_visible;

    peak_meter_ballistics_hold_core DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_raw_level_db      (s_raw_level_db),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_level_db          (m_level_db),
        .m_hold_db           (m_hold_db),
        .m_level_norm        (m_level_norm),
        .m_hold_norm         (m_hold_norm),
        .m_bar_visible       (m_bar_visible),
        .m_hold_line_visible (m_hold_line_visible)
    );

    // Ticks waiting to be offered, and results the meter still owes us.
    logic signed [15:0] pending_ticks[$];
    meter_result_t      expected_results[$];

    // Shadow copy of the registers and of the meter state.
    logic [15:0] cfg_attack = 16'd32768;
    logic [15:0] cfg_release = 16'd2048;
    logic [9:0]  cfg_hold_ticks = 10'd60;
    int          meter_level = FLOOR_DB;
    int          meter_hold = FLOOR_DB;
    int          hold_count = 0;

    int          mismatches = 0;
    int          ticks_accepted = 0;
    int          cycle_count = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // One pole step: floor(coeff * diff / 2^16). The arithmetic shift of the
    // signed product floors toward minus infinity, as required.
    function automatic int ballistic_step(input logic [15:0] coeff, input int diff);
        longint c;
        longint prod;
        c = coeff;
        prod = c * diff;
        return int'(prod >>> 16);
    endfunction

    // Maps -60..0 dB onto 0..4096 with clipping at both ends.
    function automatic int db_to_height(input int db);
        if (db <= FLOOR_DB) return 0;
        if (db >= 0) return FULL_HEIGHT;
        return ((db - FLOOR_DB) * FULL_HEIGHT) / (-FLOOR_DB);
    endfunction

    // Advances the shadow meter by one tick and queues the result it implies.
    function automatic void predict_tick(input logic signed [15:0] raw);
        int            raw_db;
        logic [15:0]   coeff;
        meter_result_t r;
        raw_db = raw;
        coeff = (raw_db > meter_level) ? cfg_attack : cfg_release;
        meter_level += ballistic_step(coeff, raw_db - meter_level);
        if (meter_level >= meter_hold) begin
            meter_hold = meter_level;
            hold_count = cfg_hold_ticks;
        end else begin
            if (hold_count > 0) hold_count--;
            if (hold_count == 0) meter_hold += ballistic_step(cfg_release, meter_level - meter_hold);
        end
        r.level_db = meter_level;
        r.hold_db = meter_hold;
        r.level_norm = db_to_height(meter_level);
        r.hold_norm = db_to_height(meter_hold);
        r.bar_visible = (r.level_norm > SHOW_MIN) ? 1 : 0;
        r.hold_line_visible = (r.hold_norm > SHOW_MIN && r.hold_norm > r.level_norm + HOLD_MARGIN)
                              ? 1 : 0;
        expected_results.push_back(r);
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // One APB transfer: a setup phase, then access until pready.
    task automatic apb_access(input logic wr, input int idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= 4'(4 * idx);
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_check(input int idx, input logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, idx, '0, got);
        compare_field($sformatf("register %0d readback", idx), want, got);
    endtask

    // Writes a register, mirrors it in the shadow copy and reads it back.
    task automatic write_reg(input int idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_ATTACK:  cfg_attack = value[15:0];
            REG_RELEASE: cfg_release = value[15:0];
            REG_HOLD:    cfg_hold_ticks = value[9:0];
            default: ;
        endcase
        read_check(idx, value);
    endtask

    task automatic set_config(input logic [15:0] atk, input logic [15:0] rel, input logic [9:0] ht);
        write_reg(REG_ATTACK, {16'd0, atk});
        write_reg(REG_RELEASE, {16'd0, rel});
        write_reg(REG_HOLD, {22'd0, ht});
    endtask

    // The test sequence waits here until every queued tick is taken and answered.
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_coeff();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd65535;
            2: return 16'($urandom_range(1, 255));
            default: return 16'($urandom_range(256, 65534));
        endcase
    endfunction

    function automatic logic [9:0] pick_hold();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1;
            2: return 10'd1023;
            default: return 10'($urandom_range(2, 40));
        endcase
    endfunction

    // Queues a mix of program-like material: peaks followed by silence,
    // steady levels long enough that the hold may run out, and raw noise
    // across the whole 16-bit range.
    task automatic queue_random_ticks(input int count);
        int n;
        int len;
        int peak;
        n = 0;
        while (n < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    peak = int'($urandom_range(0, 16000)) - 15500;
                    len = $urandom_range(1, 6);
                    repeat (len) pending_ticks.push_back(16'(peak - int'($urandom_range(0, 300))));
                    n += len;
                    len = $urandom_range(1, 10);
                    repeat (len)
                        pending_ticks.push_back(16'(FLOOR_DB - int'($urandom_range(0, 2000))));
                    n += len;
                end
                6, 7: begin
                    peak = int'($urandom_range(0, 17000)) - 16000;
                    len = $urandom_range(5, 25);
                    repeat (len) pending_ticks.push_back(16'(peak));
                    n += len;
                end
                default: begin
                    len = $urandom_range(1, 4);
                    repeat (len) pending_ticks.push_back(16'($urandom_range(0, 65535)));
                    n += len;
                end
            endcase
        end
    endtask

    // Sender: bursts of random length separated by random gaps. Valid stays
    // up with a steady payload until the transaction is taken.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_tick(s_raw_level_db);
                ticks_accepted <= ticks_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    s_valid <= 1'b1;
                    s_raw_level_db <= pending_ticks.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the stall pattern is redrawn at regular intervals, and once in the
    // run it holds off for a long stretch while ticks are still queued, so
    // the meter fills up and has to stall its input.
    logic [31:0] rx_cycle = '0;
    int          rx_mode = 0;
    int          stall_left = 0;
    logic        long_stall_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_cycle <= '0;
            rx_mode <= 0;
            stall_left <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 48 == 0) rx_mode <= $urandom_range(0, 3);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if (!long_stall_done && ticks_accepted >= 230 && pending_ticks.size() >= 10) begin
                long_stall_done <= 1'b1;
                stall_left <= LONG_STALL;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 5) == 0);
                    default: m_ready <= rx_cycle[2];
                endcase
            end
        end
    end

    // Each result transaction is checked against the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        meter_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: result with no prediction pending, level_db %0d", $time,
                         m_level_db);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                compare_field("level_db", want.level_db, m_level_db);
                compare_field("hold_db", want.hold_db, m_hold_db);
                compare_field("level_norm", want.level_norm, m_level_norm);
                compare_field("hold_norm", want.hold_norm, m_hold_norm);
                compare_field("bar_visible", want.bar_visible, m_bar_visible);
                compare_field("hold_line_visible", want.hold_line_visible, m_hold_line_visible);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values of the registers, then ticks at the default setting:
        // full-scale extremes, values around the meter floor and 0 dB.
        read_check(REG_ATTACK, 32'd32768);
        read_check(REG_RELEASE, 32'd2048);
        read_check(REG_HOLD, 32'd60);
        pending_ticks = '{16'sd32767, 16'sd32767, 16'sh8000, 16'sh8000, 16'sd0,
                          -16'sd15360, -16'sd15361, -16'sd15359, -16'sd1, 16'sd1,
                          16'sh5555, 16'shAAAA};
        wait_drained();

        // Zero coefficients: level and hold must not move at all.
        set_config(16'd0, 16'd0, 10'd0);
        pending_ticks = '{16'sd32767, 16'sh8000, 16'sd0};
        wait_drained();

        // Largest coefficients and the longest hold.
        set_config(16'd65535, 16'd65535, 10'd1023);
        pending_ticks = '{16'sd32767, 16'sh8000, -16'sd15360, 16'sd0};
        wait_drained();

        // Short hold so it runs out and decays within a few ticks.
        set_config(16'd65535, 16'd16384, 10'd2);
        pending_ticks = '{16'sd0, -16'sd15360, -16'sd15360, -16'sd15360, -16'sd15360};
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            set_config(pick_coeff(), pick_coeff(), pick_hold());
            queue_random_ticks(RANDOM_TICKS / 8);
            wait_drained();
        end

        set_config(16'd32768, 16'd2048, 10'd60);
        queue_random_ticks(20);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
